/* sv/qrbm_pkg.sv */
package qrbm_pkg;

  localparam logic [3:0] ModeByte  = 4'h4;
  localparam logic [7:0] PadFirst  = 8'd236;
  localparam logic [7:0] PadSecond = 8'd17;
  localparam int unsigned NumVersions = 10;

  localparam logic [7:0] CapacityQ [NumVersions] =
      '{8'd0, 8'd11, 8'd20, 8'd32, 8'd46, 8'd60, 8'd74, 8'd86, 8'd108, 8'd130};
  localparam logic [7:0] CodewordsQ [NumVersions] =
      '{8'd0, 8'd13, 8'd22, 8'd34, 8'd48, 8'd62, 8'd76, 8'd88, 8'd110, 8'd132};

  typedef enum logic [2:0] {
    StIdle,
    StHeader,
    StData,
    StTerm,
    StPad
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_item;
    logic emit_header;
    logic emit_data;
    logic emit_term;
    logic emit_pad;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic slot_free;
    logic last_byte;
    logic pads_zero;
    logic pad_last;
    logic in_len_zero;
    logic msg_start;
  } status_t;

  // Data codeword count of the smallest version that holds the length,
  // zero when no version holds it.
  function automatic logic [7:0] target_codewords(input logic [7:0] len);
    logic [7:0] result;
    logic       found;
    result = 8'd0;
    found  = 1'b0;
    for (int i = 0; i < NumVersions; i++) begin
      if (!found && (len <= CapacityQ[i])) begin
        result = CodewordsQ[i];
        found  = 1'b1;
      end
    end
    return result;
  endfunction

endpackage

/* sv/qr_byte_mode_codeword_builder_unit.sv */
// Byte mode data codeword builder, level Q, versions 1 to 9.
// A taken beat is stored in the item register; its first codeword (header first on a new
// message) then goes to the registered output. Middle beats go one per cycle unless the
// output stalls; a message runs idle to take its first beat, header, data, terminator, pads.
// Input stalls from the last beat until the pads are out; output stalls hold the sequencer.
// Reset (asynchronous, active low) clears the sequencer, message state and output valid.
module qr_byte_mode_codeword_builder_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  input  logic [7:0] message_length_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] codeword_o,
  output logic       message_end_o
);
  import qrbm_pkg::*;

  cmd_t    cmd;
  status_t status;

  qrbm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  qrbm_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .data_byte_i      (data_byte_i),
    .message_length_i (message_length_i),
    .cmd_i            (cmd),
    .status_o         (status),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .codeword_o       (codeword_o),
    .message_end_o    (message_end_o)
  );

endmodule

/* sv/qrbm_ctrl.sv */
module qrbm_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  qrbm_pkg::status_t status_i,
  output qrbm_pkg::cmd_t    cmd_o
);
  import qrbm_pkg::*;

  state_e state_q, state_d;
  logic   accept;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    accept     = 1'b0;
    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        accept     = in_valid_i;
      end
      StHeader: begin
        if (status_i.slot_free) begin
          cmd_o.emit_header = 1'b1;
          state_d           = StData;
        end
      end
      StData: begin
        if (status_i.slot_free) begin
          cmd_o.emit_data = 1'b1;
          if (status_i.last_byte) begin
            state_d = StTerm;
          end else begin
            // A middle byte frees the item register in the same cycle.
            in_ready_o = 1'b1;
            accept     = in_valid_i;
            state_d    = StIdle;
          end
        end
      end
      StTerm: begin
        if (status_i.slot_free) begin
          cmd_o.emit_term = 1'b1;
          state_d         = status_i.pads_zero ? StIdle : StPad;
        end
      end
      StPad: begin
        if (status_i.slot_free) begin
          cmd_o.emit_pad = 1'b1;
          if (status_i.pad_last) begin
            state_d = StIdle;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase

    // A zero length beat is dropped; a new message starts with its header.
    if (accept && !status_i.in_len_zero) begin
      cmd_o.load_item = 1'b1;
      if (state_q == StIdle && status_i.msg_start) begin
        state_d = StHeader;
      end else begin
        state_d = StData;
      end
    end
  end

endmodule

/* sv/qrbm_datapath.sv */
module qrbm_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [7:0]        data_byte_i,
  input  logic [7:0]        message_length_i,
  input  qrbm_pkg::cmd_t    cmd_i,
  output qrbm_pkg::status_t status_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [7:0]        codeword_o,
  output logic              message_end_o
);
  import qrbm_pkg::*;

  logic [7:0] item_data_q, item_len_q;
  logic [7:0] bytes_seen_q, bytes_seen_d;
  logic [3:0] held_q, held_d;
  logic [7:0] pad_cnt_q, pad_cnt_d;
  logic       pad_phase_q, pad_phase_d;
  logic       out_valid_q, out_valid_d;
  logic [7:0] out_word_q, out_word_d;
  logic       out_end_q, out_end_d;

  logic [8:0] seen_next;
  logic [8:0] emitted;
  logic [8:0] target;
  logic [7:0] pads;
  logic       emit;

  // Message position and pad count for the final byte.
  assign seen_next = {1'b0, bytes_seen_q} + 9'd1;
  assign emitted   = seen_next + 9'd2;
  assign target    = {1'b0, target_codewords(item_len_q)};
  assign pads      = (target > emitted) ? 8'(target - emitted) : 8'd0;

  assign emit = cmd_i.emit_header | cmd_i.emit_data | cmd_i.emit_term | cmd_i.emit_pad;

  assign status_o.slot_free   = !out_valid_q || out_ready_i;
  assign status_o.last_byte   = seen_next >= {1'b0, item_len_q};
  assign status_o.pads_zero   = (pad_cnt_q == 8'd0);
  assign status_o.pad_last    = (pad_cnt_q == 8'd1);
  assign status_o.in_len_zero = (message_length_i == 8'd0);
  assign status_o.msg_start   = (bytes_seen_q == 8'd0);

  // Codeword selection and state update.
  always_comb begin
    bytes_seen_d = bytes_seen_q;
    held_d       = held_q;
    pad_cnt_d    = pad_cnt_q;
    pad_phase_d  = pad_phase_q;
    out_word_d   = out_word_q;
    out_end_d    = out_end_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    if (cmd_i.emit_header) begin
      out_word_d = {ModeByte, item_len_q[7:4]};
      out_end_d  = 1'b0;
      held_d     = item_len_q[3:0];
    end
    if (cmd_i.emit_data) begin
      out_word_d = {held_q, item_data_q[7:4]};
      out_end_d  = 1'b0;
      held_d     = item_data_q[3:0];
      if (status_o.last_byte) begin
        bytes_seen_d = 8'd0;
        pad_cnt_d    = pads;
        pad_phase_d  = 1'b0;
      end else begin
        bytes_seen_d = seen_next[7:0];
      end
    end
    if (cmd_i.emit_term) begin
      out_word_d = {held_q, 4'h0};
      out_end_d  = status_o.pads_zero;
      held_d     = 4'h0;
    end
    if (cmd_i.emit_pad) begin
      out_word_d  = pad_phase_q ? PadSecond : PadFirst;
      out_end_d   = status_o.pad_last;
      pad_cnt_d   = pad_cnt_q - 8'd1;
      pad_phase_d = !pad_phase_q;
    end
    if (emit) begin
      out_valid_d = 1'b1;
    end
  end

  // Control and message state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bytes_seen_q <= 8'd0;
      held_q       <= 4'h0;
      pad_cnt_q    <= 8'd0;
      pad_phase_q  <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      bytes_seen_q <= bytes_seen_d;
      held_q       <= held_d;
      pad_cnt_q    <= pad_cnt_d;
      pad_phase_q  <= pad_phase_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Item and output payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      item_data_q <= data_byte_i;
      item_len_q  <= message_length_i;
    end
    out_word_q <= out_word_d;
    out_end_q  <= out_end_d;
  end

  assign out_valid_o   = out_valid_q;
  assign codeword_o    = out_word_q;
  assign message_end_o = out_end_q;

endmodule
